/* hdl/tpi_pkg.sv */
// ----------------------------------------------------------------------------
// tpi_pkg: shared definitions for the two-pole integrator bank
// Field widths, register indexes, coefficient reset values, queue depths
// and the coefficient bundle handed from the front end to the back end.
// ----------------------------------------------------------------------------
package tpi_pkg;

  // fixed field widths
  localparam int CHAN_W    = 8;
  localparam int COEF_W    = 32;
  localparam int STATE_W   = 32;
  localparam int CFG_IDX_W = 2;

  // defaults for the top-level parameters
  localparam int CHANNELS_DEF     = 256;
  localparam int SAMPLE_WIDTH_DEF = 24;

  // queue depths: request queue between front and back, result queue at output
  localparam int IQ_DEPTH = 4;
  localparam int OQ_DEPTH = 8;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_A1 = 2'd0,
    REG_COEF_A2 = 2'd1,
    REG_COEF_B1 = 2'd2
  } tpi_reg_t;

  // coefficient reset values, Q2.30
  localparam logic signed [COEF_W-1:0] COEF_A1_RST = -32'sd1073741824;
  localparam logic signed [COEF_W-1:0] COEF_A2_RST = 32'sd268435456;
  localparam logic signed [COEF_W-1:0] COEF_B1_RST = 32'sd268435456;

  // filter coefficients shared by all channels
  typedef struct packed {
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic signed [COEF_W-1:0] b1;
  } tpi_coef_t;

endpackage

/* hdl/tpi_in_if.sv */
// ----------------------------------------------------------------------------
// tpi_in_if: sample request channel
// Carries one channel number and one complex sample per request.
// ----------------------------------------------------------------------------
interface tpi_in_if #(
  parameter int SAMPLE_WIDTH = tpi_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic [tpi_pkg::CHAN_W-1:0]     channel;
  logic signed [SAMPLE_WIDTH-1:0] in_re;
  logic signed [SAMPLE_WIDTH-1:0] in_im;

  modport source (output valid, channel, in_re, in_im, input ready);
  modport sink   (input valid, channel, in_re, in_im, output ready);
endinterface

/* hdl/tpi_out_if.sv */
// ----------------------------------------------------------------------------
// tpi_out_if: filtered result channel
// Carries the channel, the rounded complex output and the saturation flag.
// ----------------------------------------------------------------------------
interface tpi_out_if #(
  parameter int SAMPLE_WIDTH = tpi_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic [tpi_pkg::CHAN_W-1:0]     out_channel;
  logic signed [SAMPLE_WIDTH-1:0] out_re;
  logic signed [SAMPLE_WIDTH-1:0] out_im;
  logic                           saturated;

  modport source (output valid, out_channel, out_re, out_im, saturated, input ready);
  modport sink   (input valid, out_channel, out_re, out_im, saturated, output ready);
endinterface

/* hdl/tpi_cfg_if.sv */
// ----------------------------------------------------------------------------
// tpi_cfg_if: configuration write channel
// Carries a register index and 32-bit write data per request.
// ----------------------------------------------------------------------------
interface tpi_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tpi_pkg::CFG_IDX_W-1:0] index;
  logic [tpi_pkg::COEF_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/tpi_ram.sv */
// ----------------------------------------------------------------------------
// tpi_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered (read-first).
// ----------------------------------------------------------------------------
module tpi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

/* hdl/tpi_fifo.sv */
// ----------------------------------------------------------------------------
// tpi_fifo: small register-based FIFO with show-ahead read
// Used as the request queue and as the result queue.
// ----------------------------------------------------------------------------
module tpi_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [WIDTH-1:0]             push_data,
  input  logic                         pop,
  output logic [WIDTH-1:0]             pop_data,
  output logic                         empty,
  output logic                         full,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign pop_data = mem_r[rd_ptr_r];
  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == CW'(DEPTH));
  assign count    = cnt_r;

  // pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* hdl/tpi_front.sv */
// ----------------------------------------------------------------------------
// tpi_front: request intake and coefficient registers
// Takes configuration writes, accepts sample requests, flags channels out
// of range and pushes each request into the queue toward the back end.
// ----------------------------------------------------------------------------
module tpi_front #(
  parameter int CHANNELS     = tpi_pkg::CHANNELS_DEF,
  parameter int SAMPLE_WIDTH = tpi_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  tpi_in_if.sink                                        in_ch,
  tpi_cfg_if.sink                                       cfg_ch,
  input  logic                                          clearing,
  input  logic                                          q_full,
  output logic                                          q_push,
  output logic [1+tpi_pkg::CHAN_W+2*SAMPLE_WIDTH-1:0]   q_data,
  output tpi_pkg::tpi_coef_t                            coef
);

  localparam int CMP_W = ($clog2(CHANNELS + 1) > tpi_pkg::CHAN_W) ?
                         $clog2(CHANNELS + 1) : tpi_pkg::CHAN_W;

  tpi_pkg::tpi_coef_t coef_r;
  logic               cfg_wr;
  logic               in_range;

  // coefficient registers, writable at any time
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid & cfg_ch.ready;
  assign coef         = coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.a1 <= tpi_pkg::COEF_A1_RST;
      coef_r.a2 <= tpi_pkg::COEF_A2_RST;
      coef_r.b1 <= tpi_pkg::COEF_B1_RST;
    end else if (cfg_wr) begin
      unique case (cfg_ch.index)
        tpi_pkg::REG_COEF_A1: coef_r.a1 <= $signed(cfg_ch.data);
        tpi_pkg::REG_COEF_A2: coef_r.a2 <= $signed(cfg_ch.data);
        tpi_pkg::REG_COEF_B1: coef_r.b1 <= $signed(cfg_ch.data);
        default: ; // unlisted index: write dropped
      endcase
    end
  end

  // intake: held off while the state clear runs or the queue is full
  assign in_ch.ready = ~q_full & ~clearing;
  assign q_push      = in_ch.valid & in_ch.ready;
  assign in_range    = (CMP_W'(in_ch.channel) < CMP_W'(CHANNELS));
  assign q_data      = {in_range, in_ch.channel, in_ch.in_re, in_ch.in_im};

endmodule

/* hdl/tpi_back.sv */
// ----------------------------------------------------------------------------
// tpi_back: filter pipeline over the per-channel state RAM
// Issues queued requests when no older request of the same channel is in
// flight, runs y = b1*x1 - a1*y1 - a2*y2 for both parts, writes the state
// back and queues the rounded result. Also runs the state clear after reset.
// ----------------------------------------------------------------------------
module tpi_back #(
  parameter int CHANNELS     = tpi_pkg::CHANNELS_DEF,
  parameter int SAMPLE_WIDTH = tpi_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  tpi_pkg::tpi_coef_t                            coef,
  input  logic                                          q_empty,
  input  logic [1+tpi_pkg::CHAN_W+2*SAMPLE_WIDTH-1:0]   q_head,
  output logic                                          q_pop,
  output logic                                          clearing,
  tpi_out_if.source                                     out_ch
);

  localparam int SW      = SAMPLE_WIDTH;
  localparam int CH_W    = tpi_pkg::CHAN_W;
  localparam int CF_W    = tpi_pkg::COEF_W;
  localparam int ST_W1   = tpi_pkg::STATE_W;
  localparam int AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int WORD_W  = 2 * SW + 4 * ST_W1;
  localparam int B_SHIFT = 22;
  localparam int A_SHIFT = 30;
  localparam int Y_FRAC  = 8;
  localparam int PB_W    = CF_W + SW;
  localparam int PA_W    = 2 * CF_W;
  localparam int TB_W    = PB_W - B_SHIFT;
  localparam int TA_W    = PA_W - A_SHIFT;
  localparam int SUM_W   = ((TB_W > TA_W) ? TB_W : TA_W) + 2;
  localparam int RO_W    = ST_W1 + 1 - Y_FRAC;
  localparam int OC_W    = ((RO_W > SW) ? RO_W : SW) + 1;
  localparam int OQ_W    = CH_W + 1 + 2 * SW;
  localparam int OQ_CW   = $clog2(tpi_pkg::OQ_DEPTH + 1);

  localparam logic signed [PB_W-1:0]  RND_B = PB_W'(64'sd1 <<< (B_SHIFT - 1));
  localparam logic signed [PA_W-1:0]  RND_A = PA_W'(64'sd1 <<< (A_SHIFT - 1));
  localparam logic signed [SUM_W-1:0] Y_HI  = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] Y_LO  = SUM_W'(-64'sd2147483648);
  localparam logic signed [ST_W1:0]   RND_Y = (ST_W1+1)'(64'sd1 <<< (Y_FRAC - 1));
  localparam logic signed [63:0]      O_HI64 = (64'sd1 <<< (SW - 1)) - 64'sd1;
  localparam logic signed [OC_W-1:0]  O_HI  = OC_W'(O_HI64);
  localparam logic signed [OC_W-1:0]  O_LO  = OC_W'(-O_HI64 - 64'sd1);

  // ---------------- clear pass ----------------
  logic          clr_active_r;
  logic [AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      if (clr_addr_r == AW'(CHANNELS - 1)) begin
        clr_active_r <= 1'b0;
      end else begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
    end
  end

  assign clearing = clr_active_r;

  // ---------------- issue stage ----------------
  logic                 h_inr;
  logic [CH_W-1:0]      h_chan;
  logic signed [SW-1:0] h_x [2];
  logic [AW-1:0]        h_addr;
  logic                 hazard;
  logic [1:0]           inflight;
  logic                 credit_ok;
  logic                 issue;

  logic                 s1_v_r, s2_v_r, s3_v_r;
  logic                 s1_inr_r, s2_inr_r, s3_inr_r;
  logic [AW-1:0]        s1_addr_r, s2_addr_r, s3_addr_r;
  logic [CH_W-1:0]      s1_chan_r, s2_chan_r, s3_chan_r;
  logic signed [SW-1:0] s1_x_r [2];
  logic signed [SW-1:0] s2_x_r [2];
  logic signed [SW-1:0] s3_x_r [2];
  logic signed [ST_W1-1:0] s3_y1_r [2];

  logic [OQ_CW-1:0]     oq_count;
  logic                 oq_empty, oq_full, oq_pop;
  logic [OQ_W-1:0]      oq_push_data, oq_head;

  assign h_inr  = q_head[2*SW + CH_W];
  assign h_chan = q_head[2*SW +: CH_W];
  assign h_x[0] = $signed(q_head[SW +: SW]);
  assign h_x[1] = $signed(q_head[0 +: SW]);
  assign h_addr = AW'(h_chan);

  // same channel still in flight: its state write has not landed yet
  assign hazard = h_inr & (
                  (s1_v_r & s1_inr_r & (s1_addr_r == h_addr)) |
                  (s2_v_r & s2_inr_r & (s2_addr_r == h_addr)) |
                  (s3_v_r & s3_inr_r & (s3_addr_r == h_addr)));

  // reserve a result-queue slot for every request in flight
  assign inflight  = {1'b0, s1_v_r} + {1'b0, s2_v_r} + {1'b0, s3_v_r};
  assign credit_ok = ((OQ_CW+1)'(oq_count) + (OQ_CW+1)'(inflight)) <
                     (OQ_CW+1)'(tpi_pkg::OQ_DEPTH);
  assign issue     = ~clr_active_r & ~q_empty & ~hazard & credit_ok;
  assign q_pop     = issue;

  // ---------------- state RAM ----------------
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;
  logic signed [ST_W1-1:0] y_new [2];

  assign ram_we    = clr_active_r | (s3_v_r & s3_inr_r);
  assign ram_waddr = clr_active_r ? clr_addr_r : s3_addr_r;
  assign ram_wdata = clr_active_r ? '0 :
                     {s3_x_r[0], s3_x_r[1], y_new[0], y_new[1], s3_y1_r[0], s3_y1_r[1]};

  tpi_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CHANNELS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (h_addr),
    .rdata (ram_rdata)
  );

  // ---------------- stage 1: products ----------------
  logic signed [CF_W-1:0]  c_a1, c_a2, c_b1;
  logic signed [SW-1:0]    x_old [2];
  logic signed [ST_W1-1:0] y1_old [2];
  logic signed [ST_W1-1:0] y2_old [2];
  logic signed [PB_W-1:0]  pb [2];
  logic signed [PA_W-1:0]  pa [2];
  logic signed [PA_W-1:0]  pc [2];

  assign c_a1 = coef.a1;
  assign c_a2 = coef.a2;
  assign c_b1 = coef.b1;

  assign x_old[0]  = $signed(ram_rdata[WORD_W-1 -: SW]);
  assign x_old[1]  = $signed(ram_rdata[WORD_W-SW-1 -: SW]);
  assign y1_old[0] = $signed(ram_rdata[4*ST_W1-1 -: ST_W1]);
  assign y1_old[1] = $signed(ram_rdata[3*ST_W1-1 -: ST_W1]);
  assign y2_old[0] = $signed(ram_rdata[2*ST_W1-1 -: ST_W1]);
  assign y2_old[1] = $signed(ram_rdata[ST_W1-1 -: ST_W1]);

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      pb[i] = c_b1 * x_old[i];
      pa[i] = c_a1 * y1_old[i];
      pc[i] = c_a2 * y2_old[i];
    end
  end

  // ---------------- stage 2: round and sum ----------------
  logic signed [PB_W-1:0]  s2_pb_r [2];
  logic signed [PA_W-1:0]  s2_pa_r [2];
  logic signed [PA_W-1:0]  s2_pc_r [2];
  logic signed [ST_W1-1:0] s2_y1_r [2];
  logic signed [PB_W-1:0]  rb [2];
  logic signed [PA_W-1:0]  ra [2];
  logic signed [PA_W-1:0]  rc [2];
  logic signed [TB_W-1:0]  tb [2];
  logic signed [TA_W-1:0]  ta [2];
  logic signed [TA_W-1:0]  tc [2];
  logic signed [SUM_W-1:0] sum [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      rb[i]  = s2_pb_r[i] + RND_B;
      ra[i]  = s2_pa_r[i] + RND_A;
      rc[i]  = s2_pc_r[i] + RND_A;
      tb[i]  = $signed(rb[i][PB_W-1:B_SHIFT]);
      ta[i]  = $signed(ra[i][PA_W-1:A_SHIFT]);
      tc[i]  = $signed(rc[i][PA_W-1:A_SHIFT]);
      sum[i] = SUM_W'(tb[i]) - SUM_W'(ta[i]) - SUM_W'(tc[i]);
    end
  end

  // ---------------- stage 3: saturate, output round, write back ----------------
  logic signed [SUM_W-1:0] s3_sum_r [2];
  logic signed [ST_W1:0]   ry [2];
  logic signed [RO_W-1:0]  ro [2];
  logic signed [OC_W-1:0]  roe [2];
  logic signed [SW-1:0]    o_val [2];
  logic                    sat_any;

  always_comb begin
    sat_any = 1'b0;
    for (int i = 0; i < 2; i++) begin
      if (s3_sum_r[i] > Y_HI) begin
        y_new[i] = Y_HI[ST_W1-1:0];
        sat_any  = 1'b1;
      end else if (s3_sum_r[i] < Y_LO) begin
        y_new[i] = Y_LO[ST_W1-1:0];
        sat_any  = 1'b1;
      end else begin
        y_new[i] = s3_sum_r[i][ST_W1-1:0];
      end
      ry[i]  = (ST_W1+1)'(y_new[i]) + RND_Y;
      ro[i]  = $signed(ry[i][ST_W1:Y_FRAC]);
      roe[i] = OC_W'(ro[i]);
      if (roe[i] > O_HI) begin
        o_val[i] = O_HI[SW-1:0];
        sat_any  = 1'b1;
      end else if (roe[i] < O_LO) begin
        o_val[i] = O_LO[SW-1:0];
        sat_any  = 1'b1;
      end else begin
        o_val[i] = roe[i][SW-1:0];
      end
    end
    // out-of-range channel: zero result, no flag
    if (!s3_inr_r) begin
      sat_any  = 1'b0;
      o_val[0] = '0;
      o_val[1] = '0;
    end
  end

  // ---------------- pipeline registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_inr_r  <= h_inr;
    s1_addr_r <= h_addr;
    s1_chan_r <= h_chan;
    s2_inr_r  <= s1_inr_r;
    s2_addr_r <= s1_addr_r;
    s2_chan_r <= s1_chan_r;
    s3_inr_r  <= s2_inr_r;
    s3_addr_r <= s2_addr_r;
    s3_chan_r <= s2_chan_r;
    for (int i = 0; i < 2; i++) begin
      s1_x_r[i]   <= h_x[i];
      s2_x_r[i]   <= s1_x_r[i];
      s2_pb_r[i]  <= pb[i];
      s2_pa_r[i]  <= pa[i];
      s2_pc_r[i]  <= pc[i];
      s2_y1_r[i]  <= y1_old[i];
      s3_x_r[i]   <= s2_x_r[i];
      s3_sum_r[i] <= sum[i];
      s3_y1_r[i]  <= s2_y1_r[i];
    end
  end

  // ---------------- result queue ----------------
  assign oq_push_data = {s3_chan_r, sat_any, o_val[0], o_val[1]};
  assign oq_pop       = out_ch.valid & out_ch.ready;

  tpi_fifo #(
    .WIDTH (OQ_W),
    .DEPTH (tpi_pkg::OQ_DEPTH)
  ) u_result_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s3_v_r),
    .push_data (oq_push_data),
    .pop       (oq_pop),
    .pop_data  (oq_head),
    .empty     (oq_empty),
    .full      (oq_full),
    .count     (oq_count)
  );

  assign out_ch.valid       = ~oq_empty;
  assign out_ch.out_channel = oq_head[OQ_W-1 -: CH_W];
  assign out_ch.saturated   = oq_head[2*SW];
  assign out_ch.out_re      = $signed(oq_head[SW +: SW]);
  assign out_ch.out_im      = $signed(oq_head[0 +: SW]);

  // ---------------- assertions ----------------
  a_no_raw_conflict: assert property (@(posedge clk) disable iff (!rst_n)
    !(issue && h_inr && s3_v_r && s3_inr_r && (s3_addr_r == h_addr)))
    else $error("request issued while same channel state write pending");

  a_result_room: assert property (@(posedge clk) disable iff (!rst_n)
    !(s3_v_r && oq_full))
    else $error("result pushed into full result queue");

  a_result_from_issue: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r |-> $past(issue, 3))
    else $error("result without a matching issue");

  a_clear_complete: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clr_active_r) |-> ($past(clr_addr_r) == AW'(CHANNELS - 1)))
    else $error("state clear ended early");

endmodule

/* hdl/two_pole_integrator_bank.sv */
// ----------------------------------------------------------------------------
// two_pole_integrator_bank: per-channel second-order leaky integrators
// Complex samples tagged with a channel run through
// y = b1*x[n-1] - a1*y[n-1] - a2*y[n-2] using that channel's stored state.
//
// Channels: cfg_ch writes coef_a1 (0), coef_a2 (1), coef_b1 (2) as Q2.30;
//   in_ch takes channel/in_re/in_im; out_ch returns out_channel, out_re,
//   out_im and saturated. A request moves on valid and ready both high.
// Path: an accepted request passes the request queue, RAM read, multiply,
//   round/sum and saturate/write back, then waits in the result queue.
// Throughput: one request per cycle while result-queue slots are free and
//   each request's channel differs from the three before it in the back
//   pipeline; a repeated channel waits for the earlier state write before it
//   issues again. The bound is the state RAM read-to-write loop.
// Reset: coefficients take their reset values, then a clear pass writes
//   zero state to all CHANNELS entries, one per cycle; in_ch.ready stays low
//   while the clear pass runs. cfg_ch is always ready.
// Output stall: results wait in an 8-entry queue; the back end issues only
//   with a free slot reserved, and the input queue absorbs short stalls.
// ----------------------------------------------------------------------------
module two_pole_integrator_bank #(
  parameter int CHANNELS     = tpi_pkg::CHANNELS_DEF,
  parameter int SAMPLE_WIDTH = tpi_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tpi_cfg_if.sink    cfg_ch,
  tpi_in_if.sink     in_ch,
  tpi_out_if.source  out_ch
);

  localparam int ENT_W = 1 + tpi_pkg::CHAN_W + 2 * SAMPLE_WIDTH;
  localparam int IQ_CW = $clog2(tpi_pkg::IQ_DEPTH + 1);

  tpi_pkg::tpi_coef_t coef;
  logic               clearing;
  logic               q_push, q_pop, q_empty, q_full;
  logic [ENT_W-1:0]   q_data, q_head;
  logic [IQ_CW-1:0]   q_count;
  logic               q_busy;

  // front end: intake and coefficients
  tpi_front #(
    .CHANNELS     (CHANNELS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .clearing (clearing),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_data),
    .coef     (coef)
  );

  // request queue between the two sides
  tpi_fifo #(
    .WIDTH (ENT_W),
    .DEPTH (tpi_pkg::IQ_DEPTH)
  ) u_req_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .pop_data  (q_head),
    .empty     (q_empty),
    .full      (q_full),
    .count     (q_count)
  );

  assign q_busy = (q_count != '0);

  // back end: filter pipeline and result queue
  tpi_back #(
    .CHANNELS     (CHANNELS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .coef     (coef),
    .q_empty  (~q_busy),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .clearing (clearing),
    .out_ch   (out_ch)
  );

  // the empty flag and the occupancy must agree
  a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (q_empty == !q_busy) && !(q_full && q_empty))
    else $error("request queue flags inconsistent");

endmodule
